// ===== src/lru_cache_table_assert.svh =====
// ----------------------------------------------------------------------------
// lru_cache_table_assert.svh
// Assertion macros shared by the cache table RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_TABLE_ASSERT_SVH
`define LRU_CACHE_TABLE_ASSERT_SVH

// Clocked on aclk, muted while aresetn is low.
`define LRU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same-cycle implication.
`define LRU_ASSERT_IMP(lbl, ante, cons, msg) \
    `LRU_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define LRU_ASSERT_NXT(lbl, ante, cons, msg) \
    `LRU_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== src/lru_pkg.sv =====
// ----------------------------------------------------------------------------
// lru_pkg
// Types and constants for the fully associative LRU cache table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lru_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 5;
    localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE     = '1;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [VAL_W-1:0]   val_t;
    typedef logic [RANK_W-1:0]  rank_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [ENTRIES-1:0] entry_vec_t;

    typedef struct packed {
        entry_vec_t hit_vec;    // matching valid entry, at most one
        entry_vec_t free_oh;    // lowest invalid entry
        entry_vec_t victim_oh;  // least recent valid entry
        rank_t      hit_rank;
        val_t       hit_value;
    } match_t;

endpackage

`default_nettype wire

// ===== src/lru_match.sv =====
// ----------------------------------------------------------------------------
// lru_match
// Parallel key compare, free slot pick and LRU victim pick over all entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_match (
    input  wire lru_pkg::key_t       key_i,
    input  wire lru_pkg::key_t       keys_i   [lru_pkg::ENTRIES],
    input  wire lru_pkg::val_t       vals_i   [lru_pkg::ENTRIES],
    input  wire lru_pkg::rank_t      ranks_i  [lru_pkg::ENTRIES],
    input  wire lru_pkg::entry_vec_t valid_i,
    input  wire lru_pkg::cnt_t       count_i,
    output lru_pkg::match_t          match_o
);

    lru_pkg::rank_t oldest_rank;

    // valid ranks are a permutation of 0..count-1, so the oldest holds count-1
    assign oldest_rank = lru_pkg::RANK_W'(count_i - lru_pkg::CNT_W'(1));

    always_comb begin
        match_o = '0;
        for (int i = 0; i < lru_pkg::ENTRIES; i++) begin
            match_o.hit_vec[i]   = valid_i[i] && (keys_i[i] == key_i);
            match_o.victim_oh[i] = valid_i[i] && (ranks_i[i] == oldest_rank);
        end
        // lowest zero bit of the valid vector
        match_o.free_oh = ~valid_i & (valid_i + lru_pkg::ENTRIES'(1));
        for (int i = 0; i < lru_pkg::ENTRIES; i++) begin
            if (match_o.hit_vec[i]) begin
                match_o.hit_rank  = match_o.hit_rank | ranks_i[i];
                match_o.hit_value = match_o.hit_value | vals_i[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/lru_cache_table.sv =====
// ----------------------------------------------------------------------------
// lru_cache_table
// Fully associative key/value cache, 16 entries, least recently used eviction.
// ----------------------------------------------------------------------------
//  port group  | dir | contents
//  s_*         | in  | tdata: lookup_key[31:0], write_value[63:32]; tuser: opcode
//  m_*         | out | tdata: read_value[31:0]; tuser: hit
//  cfg_*       | in  | capacity_in_use, written when cfg_we is high
//
//  One request per cycle while no get waits. A get gives its result through the
//  input register, then the result register; puts give no beat.
//  The compare, victim pick and rank update run between the two registers.
//  A get waits in the input register while the result register is full and
//  not taken; a put never waits. Reset clears valid bits, ranks and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lru_cache_table_assert.svh"

module lru_cache_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata,   // capacity_in_use
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,     // [31:0] lookup_key, [63:32] write_value
    input  wire logic [0:0]  s_tuser,     // [0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,     // [31:0] read_value
    output logic [0:0]       m_tuser      // [0] hit
);

    // configuration
    logic [lru_pkg::CFG_W-1:0] cap_reg;
    logic [lru_pkg::CAP_W-1:0] eff_cap;

    // input register
    logic               in_vld_reg, in_vld_next;
    lru_pkg::op_t       in_op_reg;
    lru_pkg::key_t      in_key_reg;
    lru_pkg::val_t      in_val_reg;

    // table state
    lru_pkg::key_t       keys_reg  [lru_pkg::ENTRIES];
    lru_pkg::val_t       vals_reg  [lru_pkg::ENTRIES];
    lru_pkg::rank_t      rank_reg  [lru_pkg::ENTRIES];
    lru_pkg::rank_t      rank_next [lru_pkg::ENTRIES];
    lru_pkg::entry_vec_t valid_reg, valid_next;
    lru_pkg::entry_vec_t wr_vec;
    lru_pkg::cnt_t       cnt_reg, cnt_next;

    // result register
    logic               m_tvalid_reg, m_tvalid_next;
    lru_pkg::val_t      m_data_reg;
    logic               m_hit_reg;

    lru_pkg::match_t     match;
    logic                stage_fire, is_put, is_get, hit, full;
    logic                touch_en, ins_en;
    lru_pkg::entry_vec_t touch_oh;
    lru_pkg::rank_t      touch_rank;

    lru_match u_match (
        .key_i   (in_key_reg),
        .keys_i  (keys_reg),
        .vals_i  (vals_reg),
        .ranks_i (rank_reg),
        .valid_i (valid_reg),
        .count_i (cnt_reg),
        .match_o (match)
    );

    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = lru_pkg::CAP_W'(1);
        end else if (lru_pkg::CAP_W'(cap_reg) > lru_pkg::CAP_W'(lru_pkg::ENTRIES)) begin
            eff_cap = lru_pkg::CAP_W'(lru_pkg::ENTRIES);
        end else begin
            eff_cap = lru_pkg::CAP_W'(cap_reg);
        end
    end

    assign is_put     = (in_op_reg == lru_pkg::OP_PUT);
    assign is_get     = (in_op_reg == lru_pkg::OP_GET);
    assign stage_fire = in_vld_reg && (is_put || !m_tvalid_reg || m_tready);
    assign s_tready   = !in_vld_reg || stage_fire;

    assign hit  = |match.hit_vec;
    assign full = lru_pkg::CAP_W'(cnt_reg) >= eff_cap;

    // a hit, or an eviction, moves one entry to the front
    assign touch_en   = stage_fire && (hit || (is_put && full));
    assign touch_oh   = hit ? match.hit_vec : match.victim_oh;
    assign touch_rank = hit ? match.hit_rank
                            : lru_pkg::RANK_W'(cnt_reg - lru_pkg::CNT_W'(1));
    assign ins_en     = stage_fire && is_put && !hit && !full;

    always_comb begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        wr_vec     = '0;
        if (stage_fire && is_put) begin
            wr_vec = hit ? match.hit_vec : (full ? match.victim_oh : match.free_oh);
        end
        for (int i = 0; i < lru_pkg::ENTRIES; i++) begin
            rank_next[i] = rank_reg[i];
            if (touch_en) begin
                if (touch_oh[i]) begin
                    rank_next[i] = '0;
                end else if (valid_reg[i] && (rank_reg[i] < touch_rank)) begin
                    rank_next[i] = rank_reg[i] + lru_pkg::RANK_W'(1);
                end
            end else if (ins_en) begin
                if (match.free_oh[i]) begin
                    rank_next[i]  = '0;
                    valid_next[i] = 1'b1;
                end else if (valid_reg[i]) begin
                    rank_next[i] = rank_reg[i] + lru_pkg::RANK_W'(1);
                end
            end
        end
        if (ins_en) begin
            cnt_next = cnt_reg + lru_pkg::CNT_W'(1);
        end
    end

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready) begin
            in_vld_next = 1'b1;
        end else if (stage_fire) begin
            in_vld_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        if (stage_fire && is_get) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= lru_pkg::CAPACITY_RESET;
            in_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            valid_reg    <= '0;
            cnt_reg      <= '0;
            for (int i = 0; i < lru_pkg::ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            in_vld_reg   <= in_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            valid_reg    <= valid_next;
            cnt_reg      <= cnt_next;
            for (int i = 0; i < lru_pkg::ENTRIES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg  <= lru_pkg::op_t'(s_tuser[0]);
            in_key_reg <= s_tdata[31:0];
            in_val_reg <= s_tdata[63:32];
        end
        if (stage_fire && is_get) begin
            m_hit_reg  <= hit;
            m_data_reg <= hit ? match.hit_value : lru_pkg::MISS_VALUE;
        end
        for (int i = 0; i < lru_pkg::ENTRIES; i++) begin
            if (wr_vec[i]) begin
                keys_reg[i] <= in_key_reg;
                vals_reg[i] <= in_val_reg;
            end
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_hit_reg;

    `LRU_ASSERT(a_cnt_matches_valid, $countones(valid_reg) == cnt_reg, "count differs from valid bits")
    `LRU_ASSERT(a_cnt_bound, cnt_reg <= lru_pkg::CNT_W'(lru_pkg::ENTRIES), "count beyond table size")
    `LRU_ASSERT_NXT(a_get_beat, stage_fire && is_get, m_tvalid_reg, "get did not produce a beat")
    `LRU_ASSERT_IMP(a_single_hit, stage_fire, $onehot0(match.hit_vec), "key held by two entries")

endmodule

`default_nettype wire
